>>> design/tcp_flow_table_counter_assert.svh
// assertion macros used by the flow table counter module
`ifndef TCP_FLOW_TABLE_COUNTER_ASSERT_SVH
`define TCP_FLOW_TABLE_COUNTER_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define FTC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the next cycle
`define FTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tft_pkg.sv
`default_nettype none
package tft_pkg;
  localparam int unsigned TupleW   = 96;
  localparam int unsigned KeyW     = 96;
  localparam int unsigned ExpW     = 64;
  localparam int unsigned PktW     = 32;
  localparam int unsigned CountW   = 11;
  localparam int unsigned TimeoutW = 40;
  localparam int unsigned CfgIdxW  = 1;
  localparam logic [CfgIdxW-1:0] CfgEnable  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTimeout = 1'b1;
  localparam logic [TimeoutW-1:0] DefaultTimeout = 40'd10000000000;
  localparam logic [PktW-1:0] PktMax = 32'hFFFF_FFFF;

  // one way of a set as stored in memory
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ExpW-1:0] expiry;
    logic [PktW-1:0] packets;
  } entry_t;

  // per item decision handed from the lookup to the sequencer
  typedef struct packed {
    logic            do_write;
    logic            clr_valid;
    logic            set_valid;
    logic            inc_live;
    logic            dec_live;
    logic            new_flow;
    logic            overflow;
    logic [PktW-1:0] packets;
    entry_t          wr_entry;
  } decision_t;
endpackage
`default_nettype wire

>>> design/tft_ram.sv
`default_nettype none
module tft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                                          clk,
  input  wire                                          wr_en,
  input  wire [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  wr_addr,
  input  wire [Width-1:0]                              wr_data,
  input  wire [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  rd_addr,
  output logic [Width-1:0]                             rd_data
);
  logic [Width-1:0] mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

>>> design/tft_lookup.sv
`default_nettype none
module tft_lookup #(
  parameter int unsigned Ways = 4
) (
  input  wire                                         fin,
  input  wire [tft_pkg::KeyW-1:0]                     key,
  input  wire [tft_pkg::ExpW-1:0]                     now,
  input  wire [tft_pkg::ExpW-1:0]                     expiry,
  input  wire [Ways-1:0]                              valid,
  input  tft_pkg::entry_t                             ways [Ways],
  output logic [((Ways > 1) ? $clog2(Ways) : 1)-1:0]  way_sel,
  output tft_pkg::decision_t                          dec
);
  localparam int unsigned WayW = (Ways > 1) ? $clog2(Ways) : 1;
  logic [Ways-1:0] hit_v, free_v, stale_v;
  logic            hit, free, stale, old;
  logic [WayW-1:0] hit_w, free_w, stale_w;
  tft_pkg::entry_t he;
  logic [tft_pkg::PktW-1:0] base;

  // per way match and age compare
  always_comb begin
    for (int w = 0; w < Ways; w++) begin
      hit_v[w]   = valid[w] && ways[w].key == key;
      free_v[w]  = !valid[w];
      stale_v[w] = valid[w] && !hit_v[w] && now >= ways[w].expiry;
    end
  end

  // priority picks, lowest way first; last matching way wins for hits
  always_comb begin
    hit = 1'b0; free = 1'b0; stale = 1'b0;
    hit_w = '0; free_w = '0; stale_w = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (free_v[w]) begin
        free = 1'b1; free_w = WayW'(w);
      end
      if (stale_v[w]) begin
        stale = 1'b1; stale_w = WayW'(w);
      end
    end
    for (int w = 0; w < Ways; w++) begin
      if (hit_v[w]) begin
        hit = 1'b1; hit_w = WayW'(w);
      end
    end
  end

  assign he  = ways[hit_w];
  assign old = now >= he.expiry;
  assign base = old ? '0 : he.packets;

  // decide the update of the chosen way
  always_comb begin
    dec = '0;
    way_sel = hit_w;
    if (hit) begin
      dec.packets  = (base == tft_pkg::PktMax) ? base : base + 1'b1;
      dec.new_flow = old;
      dec.do_write = 1'b1;
      dec.wr_entry.key = key;
      dec.wr_entry.expiry = expiry;
      dec.wr_entry.packets = dec.packets;
      dec.clr_valid = fin;
      dec.dec_live  = fin;
    end else if (fin) begin
      dec.new_flow = 1'b1;
      dec.packets  = 'd1;
    end else if (free || stale) begin
      way_sel = free ? free_w : stale_w;
      dec.do_write = 1'b1;
      dec.set_valid = 1'b1;
      dec.inc_live  = free;
      dec.new_flow  = 1'b1;
      dec.packets   = 'd1;
      dec.wr_entry.key = key;
      dec.wr_entry.expiry = expiry;
      dec.wr_entry.packets = 'd1;
    end else begin
      dec.overflow = 1'b1;
    end
  end
endmodule
`default_nettype wire

>>> design/tcp_flow_table_counter.sv
// result: the item and the set read are registered on acceptance, then the lookup state registers the result word
// input: a new word is taken only in idle with the result slot free (set read, then write-back)
// clear: an epoch step invalidates all entries at once; when the epoch wraps
// a clearing pass over every set (256 by default) follows the result
// reset: synchronous, rst_n low; table empty, enable 1, timeout 10 s, then
// the same clearing pass runs with the input stalled before the first word
`default_nettype none
`include "tcp_flow_table_counter_assert.svh"
module tcp_flow_table_counter #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned SET_WAYS = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire [0:0]   cfg_index,
  input  wire [39:0]  cfg_data,
  input  wire         in_tvalid,
  output logic        in_tready,
  // command, is_tcp, source_address, dest_address, source_port, dest_port,
  // fin_seen, now_ns, zero fill
  input  wire [167:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // flow_count, new_flow, flow_packets, overflow, zero fill
  output logic [47:0] out_tdata
);
  localparam int unsigned Sets  = TABLE_ENTRIES / SET_WAYS;
  localparam int unsigned SetW  = (Sets > 1) ? $clog2(Sets) : 1;
  localparam int unsigned FoldB = (Sets > 1) ? $clog2(Sets + 1) - 1 : 1;
  localparam int unsigned LiveW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned WayW  = (SET_WAYS > 1) ? $clog2(SET_WAYS) : 1;
  localparam int unsigned EntW  = $bits(tft_pkg::entry_t);
  localparam int unsigned EpW   = 8;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_WIPE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic enable_r;
  logic [tft_pkg::TimeoutW-1:0] timeout_r;
  logic [LiveW-1:0] live_r;
  logic [EpW-1:0] epoch_r;
  logic [SetW-1:0] wipe_r;
  logic wipe_req_r;
  logic fin_r, act_r;
  logic [tft_pkg::KeyW-1:0] key_r;
  logic [tft_pkg::ExpW-1:0] now_r, exp_r;
  logic [SetW-1:0] set_r;
  logic [tft_pkg::CountW-1:0] o_count_r;
  logic o_new_r, o_ovf_r;
  logic [tft_pkg::PktW-1:0] o_pkts_r;

  wire        accept = in_tvalid && in_tready;
  wire        cmd    = in_tdata[0];
  wire        is_tcp = in_tdata[1];
  wire [95:0] tuple  = {in_tdata[33:2], in_tdata[65:34], in_tdata[81:66], in_tdata[97:82]};
  wire        fin    = in_tdata[98];
  wire [63:0] now    = in_tdata[162:99];
  wire        wiping = state_r == ST_WIPE;
  logic [SetW-1:0] set_idx;
  logic [64:0] exp_sum;

  // xor fold of the tuple down to the set index
  always_comb begin
    logic [SetW-1:0] acc;
    acc = '0;
    if (Sets > 1) begin
      for (int p = 0; p < 96; p += FoldB) begin
        acc ^= SetW'((tuple >> p) & ((96'd1 << FoldB) - 96'd1));
      end
    end
    set_idx = acc;
  end

  assign exp_sum = {1'b0, now} + {25'd0, timeout_r};

  // one entry memory and one tag memory per way; the tag carries valid and epoch
  tft_pkg::entry_t rd_ent [SET_WAYS];
  logic [EpW:0]    rd_tag [SET_WAYS];
  logic [SET_WAYS-1:0] valid;
  tft_pkg::decision_t dec;
  logic [WayW-1:0] way_sel;
  wire  [SetW-1:0] rd_addr = set_idx;

  for (genvar w = 0; w < SET_WAYS; w++) begin : g_way
    wire we = state_r == ST_LOOK && act_r && dec.do_write && way_sel == WayW'(w);
    tft_ram #(.Width(EntW), .Depth(Sets)) u_ent (
      .clk(clk), .wr_en(we), .wr_addr(set_r), .wr_data(dec.wr_entry),
      .rd_addr(rd_addr), .rd_data(rd_ent[w]));
    // clearing pass writes empty tags, one set per cycle
    tft_ram #(.Width(EpW + 1), .Depth(Sets)) u_tag (
      .clk(clk), .wr_en(wiping || (we && (dec.set_valid || dec.clr_valid))),
      .wr_addr(wiping ? wipe_r : set_r),
      .wr_data(wiping ? '0 : {dec.set_valid, epoch_r}),
      .rd_addr(rd_addr), .rd_data(rd_tag[w]));
    assign valid[w] = rd_tag[w][EpW] && rd_tag[w][EpW-1:0] == epoch_r;
  end

  tft_lookup #(.Ways(SET_WAYS)) u_look (
    .fin(fin_r), .key(key_r), .now(now_r), .expiry(exp_r), .valid(valid),
    .ways(rd_ent), .way_sel(way_sel), .dec(dec));

  assign in_tready = state_r == ST_IDLE && (!out_tvalid || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = wipe_req_r ? ST_WIPE : ST_IDLE;
      ST_WIPE: if (wipe_r == SetW'(Sets - 1)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WIPE;
      enable_r <= 1'b1;
      timeout_r <= tft_pkg::DefaultTimeout;
      live_r <= '0;
      epoch_r <= '0;
      wipe_r <= '0;
      wipe_req_r <= 1'b0;
      out_tvalid <= 1'b0;
      act_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == tft_pkg::CfgEnable) enable_r <= cfg_data[0];
      if (cfg_we && cfg_index == tft_pkg::CfgTimeout) timeout_r <= cfg_data;
      if (state_r == ST_LOOK) out_tvalid <= 1'b1;
      else if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      if (wiping) wipe_r <= (wipe_r == SetW'(Sets - 1)) ? '0 : wipe_r + 1'b1;
      if (accept) begin
        act_r <= !cmd && enable_r && is_tcp;
        wipe_req_r <= cmd && (epoch_r == '1);
        if (cmd) begin
          live_r <= '0;
          epoch_r <= epoch_r + 1'b1;
        end
      end
      if (state_r == ST_LOOK) begin
        if (act_r) live_r <= live_r + LiveW'(dec.inc_live) - LiveW'(dec.dec_live);
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      fin_r <= fin;
      key_r <= tuple;
      now_r <= now;
      exp_r <= exp_sum[64] ? '1 : exp_sum[63:0];
      set_r <= set_idx;
    end
    if (state_r == ST_LOOK) begin
      o_count_r <= tft_pkg::CountW'(act_r ? live_r + LiveW'(dec.inc_live)
                                            - LiveW'(dec.dec_live) : live_r);
      o_new_r  <= act_r && dec.new_flow;
      o_ovf_r  <= act_r && dec.overflow;
      o_pkts_r <= act_r ? dec.packets : '0;
    end
  end

  assign out_tdata = {3'd0, o_ovf_r, o_pkts_r, o_new_r, o_count_r};

  `FTC_ASSERT_NEXT(a_one_result, state_r == ST_LOOK, out_tvalid, "no result after lookup")
  `FTC_ASSERT_IMPL(a_no_accept_busy, state_r == ST_LOOK, !in_tready, "accept while busy")
  `FTC_ASSERT_IMPL(a_slot_free, state_r == ST_LOOK, !out_tvalid, "result slot still held")
  `FTC_ASSERT_IMPL(a_live_bound, 1'b1, live_r <= LiveW'(TABLE_ENTRIES), "live count too big")
endmodule
`default_nettype wire
